// ===== hdl/bpa_pkg.sv =====
// shared types and constants for the buddy page allocator
// no dependencies; used by every module under hdl
package bpa_pkg;

	localparam int NUM_PAGES  = 1024;
	localparam int NUM_ORDERS = 11;
	localparam int NODE_COUNT = NUM_PAGES + NUM_ORDERS;
	localparam int PAGE_W     = $clog2(NUM_PAGES);
	localparam int LINK_W     = $clog2(NODE_COUNT);
	localparam int LIST_W     = $clog2(NUM_ORDERS);
	localparam int ORD_W      = 4;
	localparam int CFG_W      = 11;
	localparam int STAT_W     = 3;
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 3;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic REG_LOW_PAGE  = 1'b0;
	localparam logic REG_HIGH_PAGE = 1'b1;

	localparam logic [CFG_W-1:0] LOW_PAGE_RST  = CFG_W'(0);
	localparam logic [CFG_W-1:0] HIGH_PAGE_RST = CFG_W'(1024);

	typedef enum logic [STAT_W-1:0] {
		ST_OK,
		ST_OOM,
		ST_RANGE,
		ST_NOT_USED,
		ST_MISALIGNED
	} status_t;

	typedef struct packed {
		logic              mode;
		logic [ORD_W-1:0]  req_order;
		logic [PAGE_W-1:0] page_index;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [PAGE_W-1:0] granted_page;
	} rsp_t;

	typedef struct packed {
		logic [CFG_W-1:0] low_page;
		logic [CFG_W-1:0] high_page;
	} cfg_t;

	typedef struct packed {
		logic              used;
		logic [ORD_W-1:0]  order;
		logic [LINK_W-1:0] next;
		logic [LINK_W-1:0] prev;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [PAGE_W-1:0] addr;
		entry_t            wdata;
	} ram_req_t;

endpackage

// ===== hdl/buddy_page_allocator_unit.sv =====
// Buddy page allocator over 1024 page entries with 11 free lists (orders 0 to 10).
// After reset the unit sweeps the entry table, marking every page used, and accepts
// no request meanwhile; apb writes are taken at any time. Each request gives one
// response. A request runs one at a time through a sequencer around a single-port
// entry ram with registered read data: an allocate scans the orders upward, then
// unlinks the block and updates its flags, then splits it level by level; a free
// checks the entry, merges with each free buddy level by level, then pushes the block.
// The ram port takes one access per cycle; a response not yet taken holds the next
// response back in the completion step, and with it any further request.
module buddy_page_allocator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  bpa_pkg::req_t                req_data,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output bpa_pkg::rsp_t                rsp_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bpa_pkg::APB_AW-1:0]   paddr,
	input  logic [bpa_pkg::APB_DW-1:0]   pwdata,
	output logic [bpa_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);

	bpa_pkg::cfg_t     cfg;
	bpa_pkg::ram_req_t mem_req;
	bpa_pkg::entry_t   mem_rdata;

	bpa_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bpa_entry_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	bpa_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

endmodule

// ===== hdl/bpa_entry_ram.sv =====
// page entry table: single-port synchronous ram with registered read data
// depends on bpa_pkg
module bpa_entry_ram (
	input  logic              clk,
	input  bpa_pkg::ram_req_t req,
	output bpa_pkg::entry_t   rdata
);

	bpa_pkg::entry_t mem [bpa_pkg::NUM_PAGES];

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata <= mem[req.addr];
			end
		end
	end

endmodule

// ===== hdl/bpa_cfg_regs.sv =====
// apb register file holding the managed page window
// depends on bpa_pkg
module bpa_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bpa_pkg::APB_AW-1:0]   paddr,
	input  logic [bpa_pkg::APB_DW-1:0]   pwdata,
	output logic [bpa_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	output bpa_pkg::cfg_t                cfg
);

	logic                        reg_sel;
	logic [bpa_pkg::CFG_W-1:0]   low_q;
	logic [bpa_pkg::CFG_W-1:0]   high_q;

	assign reg_sel = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= bpa_pkg::LOW_PAGE_RST;
			high_q <= bpa_pkg::HIGH_PAGE_RST;
		end else if (psel && penable && pwrite) begin
			if (reg_sel == bpa_pkg::REG_LOW_PAGE) begin
				low_q <= pwdata[bpa_pkg::CFG_W-1:0];
			end else begin
				high_q <= pwdata[bpa_pkg::CFG_W-1:0];
			end
		end
	end

	always_comb begin
		if (reg_sel == bpa_pkg::REG_LOW_PAGE) begin
			prdata = bpa_pkg::APB_DW'(low_q);
		end else begin
			prdata = bpa_pkg::APB_DW'(high_q);
		end
	end

	assign cfg.low_page  = low_q;
	assign cfg.high_page = high_q;

endmodule

// ===== hdl/bpa_engine.sv =====
// request sequencer: free list heads, list walk, split and merge,
// read-modify-write of the entry ram; depends on bpa_pkg
module bpa_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  bpa_pkg::cfg_t     cfg,
	input  logic              req_valid,
	output logic              req_ready,
	input  bpa_pkg::req_t     req_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output bpa_pkg::rsp_t     rsp_data,
	output bpa_pkg::ram_req_t mem_req,
	input  bpa_pkg::entry_t   mem_rdata
);

	localparam int PW = bpa_pkg::PAGE_W;
	localparam int LW = bpa_pkg::LINK_W;
	localparam int OW = bpa_pkg::ORD_W;
	localparam int IW = bpa_pkg::LIST_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_A_SCAN, S_A_UNL, S_A_META, S_A_SPLIT,
		S_F_CHK, S_F_LOOP, S_F_BUD, S_F_MERGE, S_F_PUSH, S_F_HEAD,
		S_UNL2, S_SOP, S_SOP_WR, S_DONE
	} state_t;

	typedef enum logic [1:0] {K_NEXT, K_PREV, K_META} sop_kind_t;

	state_t            state_q, sop_ret_q, unl_ret_q;
	sop_kind_t         sop_kind_q;
	logic [LW-1:0]     sop_node_q, sop_val_q;
	logic [OW-1:0]     sop_ord_q;
	logic [PW-1:0]     clr_q, blk_q, bud_q;
	logic [OW-1:0]     j_q, ord_q;
	logic [LW-1:0]     p_q, x_q;
	logic [LW-1:0]     lf_q [bpa_pkg::NUM_ORDERS];
	logic [LW-1:0]     ll_q [bpa_pkg::NUM_ORDERS];
	bpa_pkg::status_t  res_status_q;
	logic [PW-1:0]     res_page_q;
	logic              rsp_valid_q;
	bpa_pkg::rsp_t     rsp_data_q;

	logic              acc, range_bad, j_ok, nonempty, blk_bad;
	logic [LW-1:0]     idx_ext, lf_j, sent_j, bud_s, bud_f, lf_o, sent_o;
	logic [OW-1:0]     jn;
	logic              bud_s_ok, cont_ok, bud_in, mis, sop_page, sop_sent;
	logic [IW-1:0]     sop_idx;
	logic [LW-1:0]     low_l, high_l;

	assign req_ready = (state_q == S_IDLE);
	assign acc       = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	assign low_l     = LW'(cfg.low_page);
	assign high_l    = LW'(cfg.high_page);
	assign idx_ext   = LW'(req_data.page_index);
	assign range_bad = (idx_ext < low_l) || (idx_ext >= high_l) ||
		(idx_ext >= LW'(bpa_pkg::NUM_PAGES));

	// upward scan over the list heads
	assign j_ok     = j_q < OW'(bpa_pkg::NUM_ORDERS);
	assign lf_j     = lf_q[j_q[IW-1:0]];
	assign sent_j   = LW'(bpa_pkg::NUM_PAGES) + LW'(j_q);
	assign nonempty = lf_j != sent_j;
	assign blk_bad  = lf_j >= LW'(bpa_pkg::NUM_PAGES);

	// split: upper half of the current block goes to order j-1
	assign jn       = j_q - OW'(1);
	assign bud_s    = LW'(blk_q) + (LW'(1) << jn);
	assign bud_s_ok = bud_s < LW'(bpa_pkg::NUM_PAGES);

	// merge: buddy at the current order
	assign cont_ok = ((OW + 1)'(ord_q) + (OW + 1)'(1)) < (OW + 1)'(bpa_pkg::NUM_ORDERS);
	assign bud_f   = LW'(blk_q) ^ (LW'(1) << ord_q);
	assign bud_in  = (bud_f >= low_l) && (bud_f < high_l) &&
		(bud_f < LW'(bpa_pkg::NUM_PAGES));
	assign mis     = (blk_q & ~({PW{1'b1}} << mem_rdata.order)) != '0;
	assign lf_o    = lf_q[ord_q[IW-1:0]];
	assign sent_o  = LW'(bpa_pkg::NUM_PAGES) + LW'(ord_q);

	// single link or flag update through a node code
	assign sop_page = sop_node_q < LW'(bpa_pkg::NUM_PAGES);
	assign sop_sent = !sop_page && (sop_node_q < LW'(bpa_pkg::NODE_COUNT));
	assign sop_idx  = IW'(sop_node_q - LW'(bpa_pkg::NUM_PAGES));

	always_comb begin
		mem_req = '0;
		case (state_q)
			S_CLEAR: begin
				mem_req.en         = 1'b1;
				mem_req.we         = 1'b1;
				mem_req.addr       = clr_q;
				mem_req.wdata.used = 1'b1;
			end
			S_IDLE: begin
				if (acc && req_data.mode == bpa_pkg::MODE_FREE && !range_bad) begin
					mem_req.en   = 1'b1;
					mem_req.addr = req_data.page_index;
				end
			end
			S_A_SCAN: begin
				if (j_ok && nonempty && !blk_bad) begin
					mem_req.en   = 1'b1;
					mem_req.addr = lf_j[PW-1:0];
				end
			end
			S_A_SPLIT: begin
				if (j_q != ord_q && bud_s_ok) begin
					mem_req.en          = 1'b1;
					mem_req.we          = 1'b1;
					mem_req.addr        = bud_s[PW-1:0];
					mem_req.wdata.used  = 1'b0;
					mem_req.wdata.order = jn;
					mem_req.wdata.next  = LW'(bpa_pkg::NUM_PAGES) + LW'(jn);
					mem_req.wdata.prev  = LW'(bpa_pkg::NUM_PAGES) + LW'(jn);
				end
			end
			S_F_LOOP: begin
				if (cont_ok && bud_in) begin
					mem_req.en   = 1'b1;
					mem_req.addr = bud_f[PW-1:0];
				end
			end
			S_F_PUSH: begin
				mem_req.en          = 1'b1;
				mem_req.we          = 1'b1;
				mem_req.addr        = blk_q;
				mem_req.wdata.used  = 1'b0;
				mem_req.wdata.order = ord_q;
				mem_req.wdata.next  = lf_o;
				mem_req.wdata.prev  = sent_o;
			end
			S_SOP: begin
				if (sop_page) begin
					mem_req.en   = 1'b1;
					mem_req.addr = sop_node_q[PW-1:0];
				end
			end
			S_SOP_WR: begin
				mem_req.en    = 1'b1;
				mem_req.we    = 1'b1;
				mem_req.addr  = sop_node_q[PW-1:0];
				mem_req.wdata = mem_rdata;
				case (sop_kind_q)
					K_NEXT: mem_req.wdata.next = sop_val_q;
					K_PREV: mem_req.wdata.prev = sop_val_q;
					K_META: begin
						mem_req.wdata.used  = 1'b1;
						mem_req.wdata.order = sop_ord_q;
					end
					default: mem_req.wdata = mem_rdata;
				endcase
			end
			default: mem_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			sop_ret_q    <= S_IDLE;
			unl_ret_q    <= S_IDLE;
			sop_kind_q   <= K_NEXT;
			sop_node_q   <= '0;
			sop_val_q    <= '0;
			sop_ord_q    <= '0;
			clr_q        <= '0;
			blk_q        <= '0;
			bud_q        <= '0;
			j_q          <= '0;
			ord_q        <= '0;
			p_q          <= '0;
			x_q          <= '0;
			res_status_q <= bpa_pkg::ST_OK;
			res_page_q   <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_data_q   <= '0;
			for (int k = 0; k < bpa_pkg::NUM_ORDERS; k++) begin
				lf_q[k] <= LW'(bpa_pkg::NUM_PAGES + k);
				ll_q[k] <= LW'(bpa_pkg::NUM_PAGES + k);
			end
		end else begin
			// the completion step reloads the response register itself
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == PW'(bpa_pkg::NUM_PAGES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						res_page_q <= '0;
						blk_q      <= req_data.page_index;
						j_q        <= req_data.req_order;
						ord_q      <= req_data.req_order;
						if (req_data.mode == bpa_pkg::MODE_ALLOC) begin
							state_q <= S_A_SCAN;
						end else if (range_bad) begin
							res_status_q <= bpa_pkg::ST_RANGE;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_F_CHK;
						end
					end
				end
				S_A_SCAN: begin
					if (!j_ok) begin
						res_status_q <= bpa_pkg::ST_OOM;
						state_q      <= S_DONE;
					end else if (nonempty) begin
						if (blk_bad) begin
							res_status_q <= bpa_pkg::ST_OOM;
							state_q      <= S_DONE;
						end else begin
							blk_q   <= lf_j[PW-1:0];
							state_q <= S_A_UNL;
						end
					end else begin
						j_q <= j_q + OW'(1);
					end
				end
				S_A_UNL: begin
					p_q        <= mem_rdata.prev;
					x_q        <= mem_rdata.next;
					sop_kind_q <= K_NEXT;
					sop_node_q <= mem_rdata.prev;
					sop_val_q  <= mem_rdata.next;
					sop_ret_q  <= S_UNL2;
					unl_ret_q  <= S_A_META;
					state_q    <= S_SOP;
				end
				S_A_META: begin
					sop_kind_q <= K_META;
					sop_node_q <= LW'(blk_q);
					sop_ord_q  <= ord_q;
					sop_ret_q  <= S_A_SPLIT;
					state_q    <= S_SOP;
				end
				S_A_SPLIT: begin
					if (j_q == ord_q) begin
						res_status_q <= bpa_pkg::ST_OK;
						res_page_q   <= blk_q;
						state_q      <= S_DONE;
					end else begin
						j_q <= jn;
						if (bud_s_ok) begin
							lf_q[jn[IW-1:0]] <= bud_s;
							ll_q[jn[IW-1:0]] <= bud_s;
						end
					end
				end
				S_F_CHK: begin
					if (!mem_rdata.used) begin
						res_status_q <= bpa_pkg::ST_NOT_USED;
						state_q      <= S_DONE;
					end else if (mis) begin
						res_status_q <= bpa_pkg::ST_MISALIGNED;
						state_q      <= S_DONE;
					end else begin
						ord_q   <= mem_rdata.order;
						state_q <= S_F_LOOP;
					end
				end
				S_F_LOOP: begin
					if (cont_ok && bud_in) begin
						bud_q   <= bud_f[PW-1:0];
						state_q <= S_F_BUD;
					end else begin
						state_q <= S_F_PUSH;
					end
				end
				S_F_BUD: begin
					if (mem_rdata.used || mem_rdata.order != ord_q) begin
						state_q <= S_F_PUSH;
					end else begin
						p_q        <= mem_rdata.prev;
						x_q        <= mem_rdata.next;
						sop_kind_q <= K_NEXT;
						sop_node_q <= mem_rdata.prev;
						sop_val_q  <= mem_rdata.next;
						sop_ret_q  <= S_UNL2;
						unl_ret_q  <= S_F_MERGE;
						state_q    <= S_SOP;
					end
				end
				S_F_MERGE: begin
					if (bud_q < blk_q) begin
						blk_q <= bud_q;
					end
					ord_q   <= ord_q + OW'(1);
					state_q <= S_F_LOOP;
				end
				S_F_PUSH: begin
					// old head's back link now points at the new block
					sop_kind_q <= K_PREV;
					sop_node_q <= lf_o;
					sop_val_q  <= LW'(blk_q);
					sop_ret_q  <= S_F_HEAD;
					state_q    <= S_SOP;
				end
				S_F_HEAD: begin
					lf_q[ord_q[IW-1:0]] <= LW'(blk_q);
					res_status_q        <= bpa_pkg::ST_OK;
					state_q             <= S_DONE;
				end
				S_UNL2: begin
					sop_kind_q <= K_PREV;
					sop_node_q <= x_q;
					sop_val_q  <= p_q;
					sop_ret_q  <= unl_ret_q;
					state_q    <= S_SOP;
				end
				S_SOP: begin
					if (sop_page) begin
						state_q <= S_SOP_WR;
					end else begin
						if (sop_sent) begin
							if (sop_kind_q == K_NEXT) begin
								lf_q[sop_idx] <= sop_val_q;
							end else if (sop_kind_q == K_PREV) begin
								ll_q[sop_idx] <= sop_val_q;
							end
						end
						state_q <= sop_ret_q;
					end
				end
				S_SOP_WR: begin
					state_q <= sop_ret_q;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q             <= 1'b1;
						rsp_data_q.status       <= res_status_q;
						rsp_data_q.granted_page <= res_page_q;
						state_q                 <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised outside the completion step");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !req_ready)
		else $error("request taken during table clear");

	a_rmw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SOP_WR) |-> $past(mem_req.en && !mem_req.we &&
			mem_req.addr == sop_node_q[PW-1:0]))
		else $error("entry write-back without a read of the same entry");

	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_data_q.status != bpa_pkg::ST_OK) |->
			(rsp_data_q.granted_page == '0))
		else $error("granted page set on a failed request");

endmodule

// ===== verif/bpa_checker.sv =====
// scoreboard for the buddy page allocator: watches the request, response and apb channels,
// predicts each response from its own copy of the page table and compares field by field
// depends on bpa_pkg for the payload types, status codes and register indexes
module bpa_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_ready,
	input  bpa_pkg::req_t              req_data,
	input  logic                       rsp_valid,
	input  logic                       rsp_ready,
	input  bpa_pkg::rsp_t              rsp_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [bpa_pkg::APB_AW-1:0] paddr,
	input  logic [bpa_pkg::APB_DW-1:0] pwdata,
	output int                         fail_count,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NP = bpa_pkg::NUM_PAGES;
	localparam int NO = bpa_pkg::NUM_ORDERS;
	localparam int NC = bpa_pkg::NODE_COUNT;
	localparam int LW = bpa_pkg::LINK_W;
	localparam int OW = bpa_pkg::ORD_W;
	localparam logic [bpa_pkg::APB_AW-1:0] LOW_ADDR  = {bpa_pkg::REG_LOW_PAGE, 2'b00};
	localparam logic [bpa_pkg::APB_AW-1:0] HIGH_ADDR = {bpa_pkg::REG_HIGH_PAGE, 2'b00};

	logic          pg_used [NP];
	logic [OW-1:0] pg_ord  [NP];
	logic [LW-1:0] pg_next [NP];
	logic [LW-1:0] pg_prev [NP];
	logic [LW-1:0] list_head [NO];
	logic [LW-1:0] list_tail [NO];
	int            low_pg;
	int            high_pg;
	bpa_pkg::rsp_t owed_rsp[$];

	assign pending = owed_rsp.size();

	// link codes at or above NUM_PAGES name list sentinels, beyond those nothing
	function automatic int next_of(int n);
		if (n < NP) return pg_next[n];
		if (n < NC) return list_head[n - NP];
		return n;
	endfunction

	function automatic int prev_of(int n);
		if (n < NP) return pg_prev[n];
		if (n < NC) return list_tail[n - NP];
		return n;
	endfunction

	function automatic void put_next(int n, int v);
		if (n < NP) pg_next[n] = LW'(v);
		else if (n < NC) list_head[n - NP] = LW'(v);
	endfunction

	function automatic void put_prev(int n, int v);
		if (n < NP) pg_prev[n] = LW'(v);
		else if (n < NC) list_tail[n - NP] = LW'(v);
	endfunction

	function automatic void drop_node(int n);
		int p;
		int x;
		p = prev_of(n);
		x = next_of(n);
		put_next(p, x);
		put_prev(x, p);
	endfunction

	function automatic bpa_pkg::status_t alloc_block(int ord, output int page);
		int blk;
		int bud;
		page = 0;
		for (int j = ord; j < NO; j++) begin
			if (list_head[j] == LW'(NP + j)) continue;
			blk = list_head[j];
			if (blk >= NP) return bpa_pkg::ST_OOM;
			drop_node(blk);
			pg_ord[blk] = OW'(ord);
			pg_used[blk] = 1'b1;
			// split down, upper halves go onto the lower lists
			while (j != ord) begin
				j--;
				bud = blk + (1 << j);
				if (bud < NP) begin
					pg_prev[bud] = LW'(NP + j);
					pg_next[bud] = LW'(NP + j);
					pg_ord[bud] = OW'(j);
					pg_used[bud] = 1'b0;
					list_head[j] = LW'(bud);
					list_tail[j] = LW'(bud);
				end
			end
			page = blk;
			return bpa_pkg::ST_OK;
		end
		return bpa_pkg::ST_OOM;
	endfunction

	function automatic bpa_pkg::status_t free_block(int idx);
		int ord;
		int blk;
		int bud;
		int h;
		if (idx < low_pg || idx >= high_pg || idx >= NP) return bpa_pkg::ST_RANGE;
		if (!pg_used[idx]) return bpa_pkg::ST_NOT_USED;
		ord = pg_ord[idx];
		if ((idx & ((1 << ord) - 1)) != 0) return bpa_pkg::ST_MISALIGNED;
		blk = idx;
		while (ord + 1 < NO) begin
			bud = blk ^ (1 << ord);
			if (bud < low_pg || bud >= high_pg || bud >= NP) break;
			if (pg_used[bud] || pg_ord[bud] != OW'(ord)) break;
			drop_node(bud);
			if (bud < blk) blk = bud;
			ord++;
		end
		pg_ord[blk] = OW'(ord);
		pg_used[blk] = 1'b0;
		if (ord < NO) begin
			h = list_head[ord];
			pg_prev[blk] = LW'(NP + ord);
			pg_next[blk] = LW'(h);
			put_prev(h, blk);
			list_head[ord] = LW'(blk);
		end
		return bpa_pkg::ST_OK;
	endfunction

	function automatic bpa_pkg::rsp_t serve_request(bpa_pkg::req_t r);
		bpa_pkg::rsp_t o;
		int pg;
		pg = 0;
		if (r.mode == bpa_pkg::MODE_ALLOC) begin
			o.status = alloc_block(int'(r.req_order), pg);
			if (o.status != bpa_pkg::ST_OK) pg = 0;
		end else begin
			o.status = free_block(int'(r.page_index));
		end
		o.granted_page = bpa_pkg::PAGE_W'(pg);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bpa_pkg::rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < NP; i++) begin
				pg_used[i] = 1'b1;
				pg_ord[i] = '0;
				pg_next[i] = '0;
				pg_prev[i] = '0;
			end
			for (int j = 0; j < NO; j++) begin
				list_head[j] = LW'(NP + j);
				list_tail[j] = LW'(NP + j);
			end
			low_pg = int'(bpa_pkg::LOW_PAGE_RST);
			high_pg = int'(bpa_pkg::HIGH_PAGE_RST);
			owed_rsp.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == LOW_ADDR) low_pg = int'(pwdata[bpa_pkg::CFG_W-1:0]);
				else if (paddr == HIGH_ADDR) high_pg = int'(pwdata[bpa_pkg::CFG_W-1:0]);
			end
			if (req_valid && req_ready) owed_rsp.push_back(serve_request(req_data));
			if (rsp_valid && rsp_ready) begin
				if (owed_rsp.size() == 0) begin
					$error("response transfer with nothing outstanding: status %0d page %0d",
						rsp_data.status, rsp_data.granted_page);
					fail_count++;
				end else begin
					want = owed_rsp.pop_front();
					if (rsp_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_data.status);
						fail_count++;
					end
					if (rsp_data.granted_page !== want.granted_page) begin
						$error("granted_page: expected %0d, got %0d",
							want.granted_page, rsp_data.granted_page);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ===== verif/tb.sv =====
// top of the buddy page allocator testbench: clock, reset, request and apb stimulus
// depends on bpa_pkg, buddy_page_allocator_unit and bpa_checker
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [bpa_pkg::APB_AW-1:0] LOW_ADDR  = {bpa_pkg::REG_LOW_PAGE, 2'b00};
	localparam logic [bpa_pkg::APB_AW-1:0] HIGH_ADDR = {bpa_pkg::REG_HIGH_PAGE, 2'b00};
	localparam logic ALLOC = bpa_pkg::MODE_ALLOC;
	localparam logic FREE  = bpa_pkg::MODE_FREE;
	localparam int LONG_STALL = 400;
	localparam int SETTLE = 150;

	logic                       clk;
	logic                       arst_n;
	logic                       req_valid;
	logic                       req_ready;
	bpa_pkg::req_t              req_data;
	logic                       rsp_valid;
	logic                       rsp_ready;
	bpa_pkg::rsp_t              rsp_data;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [bpa_pkg::APB_AW-1:0] paddr;
	logic [bpa_pkg::APB_DW-1:0] pwdata;
	logic [bpa_pkg::APB_DW-1:0] prdata;
	logic                       pready;
	int                         fail_count;
	int                         pending;

	int                         n_sent;
	int                         n_rcvd;
	bit                         idle_on;
	bit                         hold_rsp;
	int                         granted[$];

	buddy_page_allocator_unit u_dut (.*);

	bpa_checker u_chk (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	// pages handed out, kept for well-formed frees
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			n_rcvd++;
			if (rsp_data.status == bpa_pkg::ST_OK && rsp_data.granted_page != 0)
				granted.push_back(int'(rsp_data.granted_page));
		end
	end

	// response side: random gaps, plus one long hold-off on request
	initial begin
		int gap;
		rsp_ready = 1'b0;
		@(posedge clk);
		wait (arst_n);
		@(posedge clk);
		rsp_ready <= 1'b1;
		forever begin
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
				hold_rsp = 1'b0;
				rsp_ready <= 1'b1;
			end
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
			gap = idle_on ? $urandom_range(4, 0) : 0;
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
				rsp_ready <= 1'b1;
			end
		end
	end

	task automatic send(input logic mode, input int ord, input int page);
		int gap;
		bpa_pkg::req_t r;
		r.mode = mode;
		r.req_order = bpa_pkg::ORD_W'(ord);
		r.page_index = bpa_pkg::PAGE_W'(page);
		gap = idle_on ? $urandom_range(4, 0) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (!req_ready);
		n_sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (n_rcvd != n_sent) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(input logic [bpa_pkg::APB_AW-1:0] addr, input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= bpa_pkg::APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_window(input int lo, input int hi);
		drain();
		apb_write(LOW_ADDR, lo);
		apb_write(HIGH_ADDR, hi);
	endtask

	task automatic random_op(input int lo);
		int pick;
		int k;
		pick = $urandom_range(99, 0);
		if (pick < 50) begin
			// mostly small orders, now and then larger ones up to beyond the last list
			if ($urandom_range(9, 0) == 0) send(ALLOC, $urandom_range(15, 5), $urandom_range(1023, 0));
			else send(ALLOC, $urandom_range(4, 0), $urandom_range(1023, 0));
		end else if (pick < 85 && granted.size() > 0) begin
			k = $urandom_range(granted.size() - 1, 0);
			send(FREE, $urandom_range(15, 0), granted[k]);
			granted.delete(k);
		end else if (pick < 92) begin
			send(FREE, $urandom_range(15, 0), lo + $urandom_range(127, 0));
		end else begin
			send(FREE, $urandom_range(15, 0), $urandom_range(1023, 0));
		end
	endtask

	initial begin
		int lo;
		int hi;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		n_sent = 0;
		n_rcvd = 0;
		idle_on = 1'b1;
		hold_rsp = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pool, order past the last list, double free, reuse
		send(ALLOC, 0, 0);
		send(ALLOC, 15, 1023);
		send(FREE, 0, 1023);
		send(FREE, 0, 1023);
		send(ALLOC, 0, 0);
		for (int p = 0; p < 4; p++) send(FREE, 0, p);
		send(ALLOC, 2, 0);
		send(FREE, 0, 0);
		send(FREE, 0, 1);
		send(ALLOC, 1, 0);
		send(ALLOC, 10, 0);
		send(FREE, 0, 2);
		// window edges
		set_window(0, 1000);
		send(FREE, 0, 1010);
		send(FREE, 0, 999);
		set_window(1024, 1024);
		send(FREE, 0, 0);
		send(FREE, 0, 1023);
		set_window(0, 0);
		send(FREE, 0, 512);
		send(ALLOC, 0, 0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin lo = 0; hi = 1024; end
				1: begin lo = 512; hi = 1024; end
				2: begin lo = 256; hi = 768; end
				default: begin lo = 128 * $urandom_range(6, 0); hi = lo + 256; end
			endcase
			set_window(lo, hi);
			idle_on = (ph != 2);
			granted.delete();
			// fill a stretch of the window so later allocations succeed
			for (int p = lo; p < lo + 128; p++) send(FREE, 0, p);
			if (ph == 1) hold_rsp = 1'b1;
			repeat (100) random_op(lo);
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/bpa_pkg.sv
hdl/bpa_entry_ram.sv
hdl/bpa_cfg_regs.sv
hdl/bpa_engine.sv
hdl/buddy_page_allocator_unit.sv
verif/bpa_checker.sv
verif/tb.sv
